// File: sv/tbhp_pkg.sv
// shared types and constants for the tagged block header parser
package tbhp_pkg;

  typedef enum logic [2:0] {
    PH_MARKER  = 3'd0,
    PH_TIME    = 3'd1,
    PH_SIZE    = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PARAM   = 3'd4,
    PH_CONTENT = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_TRUNC   = 2'd2;

  // marker flag bits, each active low
  localparam int unsigned BIT_TIME_ABS  = 7;
  localparam int unsigned BIT_TYPE      = 6;
  localparam int unsigned BIT_PARAM_W   = 5;
  localparam int unsigned BIT_SIZE_W    = 4;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  channel;
    logic        time_is_absolute;
    logic [31:0] time_value;
    logic [31:0] content_size;
    logic        has_type;
    logic [7:0]  type_value;
    logic        param_is_wide;
    logic [31:0] param_value;
    logic [7:0]  content_byte;
    logic        last_of_block;
    logic [31:0] block_offset;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// File: sv/tbhp_parser.sv
// per-byte parse state and result generation
module tbhp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 buffer_end,
  output tbhp_pkg::push_t      push
);

  tbhp_pkg::phase_t phase, phase_next;
  logic [1:0]  field_byte_count, field_byte_count_next;
  logic [7:0]  marker_held, marker_held_next;
  logic [31:0] time_held, time_held_next;
  logic [31:0] size_held, size_held_next;
  logic [7:0]  type_held, type_held_next;
  logic [31:0] param_held, param_held_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] buffer_position, buffer_position_next;
  logic [31:0] block_start, block_start_next;

  logic [31:0] lane;
  logic        wide;
  logic        pri_valid;
  logic        err_valid;
  tbhp_pkg::result_t pri_res;
  tbhp_pkg::result_t err_res;

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    marker_held_next      = marker_held;
    time_held_next        = time_held;
    size_held_next        = size_held;
    type_held_next        = type_held;
    param_held_next       = param_held;
    bytes_remaining_next  = bytes_remaining;
    block_start_next      = block_start;
    lane                  = 32'(data_byte) << {field_byte_count, 3'b000};
    wide                  = 1'b0;
    pri_valid             = 1'b0;
    err_valid             = 1'b0;
    pri_res               = '0;

    unique case (phase)
      tbhp_pkg::PH_TIME: begin
        wide = !marker_held[tbhp_pkg::BIT_TIME_ABS];
        if (!wide) begin
          time_held_next = 32'(data_byte);
          phase_next     = tbhp_pkg::PH_SIZE;
        end else begin
          time_held_next = time_held | lane;
          if (field_byte_count == 2'd3) begin
            field_byte_count_next = 2'd0;
            phase_next            = tbhp_pkg::PH_SIZE;
          end else begin
            field_byte_count_next = field_byte_count + 2'd1;
          end
        end
      end
      tbhp_pkg::PH_SIZE: begin
        wide = !marker_held[tbhp_pkg::BIT_SIZE_W];
        if (!wide) begin
          size_held_next = 32'(data_byte);
          phase_next     = marker_held[tbhp_pkg::BIT_TYPE] ? tbhp_pkg::PH_PARAM
                                                           : tbhp_pkg::PH_TYPE;
        end else begin
          size_held_next = size_held | lane;
          if (field_byte_count == 2'd3) begin
            field_byte_count_next = 2'd0;
            phase_next = marker_held[tbhp_pkg::BIT_TYPE] ? tbhp_pkg::PH_PARAM
                                                         : tbhp_pkg::PH_TYPE;
          end else begin
            field_byte_count_next = field_byte_count + 2'd1;
          end
        end
      end
      tbhp_pkg::PH_TYPE: begin
        type_held_next = data_byte;
        phase_next     = tbhp_pkg::PH_PARAM;
      end
      tbhp_pkg::PH_PARAM: begin
        wide = !marker_held[tbhp_pkg::BIT_PARAM_W];
        if (!wide) begin
          param_held_next = 32'(data_byte);
          pri_valid       = 1'b1;
        end else begin
          param_held_next = param_held | lane;
          if (field_byte_count == 2'd3) begin
            field_byte_count_next = 2'd0;
            pri_valid             = 1'b1;
          end else begin
            field_byte_count_next = field_byte_count + 2'd1;
          end
        end
        if (pri_valid) begin
          pri_res.result_kind      = tbhp_pkg::KIND_HEADER;
          pri_res.time_is_absolute = !marker_held[tbhp_pkg::BIT_TIME_ABS];
          pri_res.time_value       = time_held;
          pri_res.content_size     = size_held;
          pri_res.has_type         = !marker_held[tbhp_pkg::BIT_TYPE];
          pri_res.type_value       = type_held;
          pri_res.param_is_wide    = wide;
          pri_res.param_value      = param_held_next;
          if (size_held == 32'd0) begin
            pri_res.last_of_block = 1'b1;
            phase_next            = tbhp_pkg::PH_MARKER;
          end else begin
            bytes_remaining_next = size_held;
            phase_next           = tbhp_pkg::PH_CONTENT;
          end
        end
      end
      tbhp_pkg::PH_CONTENT: begin
        pri_valid            = 1'b1;
        pri_res.result_kind  = tbhp_pkg::KIND_CONTENT;
        pri_res.content_byte = data_byte;
        bytes_remaining_next = bytes_remaining - 32'd1;
        if (bytes_remaining == 32'd1) begin
          pri_res.last_of_block = 1'b1;
          phase_next            = tbhp_pkg::PH_MARKER;
        end
      end
      default: begin
        // expect marker, also unused codes
        marker_held_next      = data_byte;
        block_start_next      = buffer_position;
        field_byte_count_next = 2'd0;
        time_held_next        = '0;
        size_held_next        = '0;
        type_held_next        = '0;
        param_held_next       = '0;
        bytes_remaining_next  = '0;
        phase_next            = tbhp_pkg::PH_TIME;
      end
    endcase

    buffer_position_next = buffer_position + 32'd1;
    if (buffer_end) begin
      if (phase_next != tbhp_pkg::PH_MARKER) begin
        err_valid             = 1'b1;
        phase_next            = tbhp_pkg::PH_MARKER;
        field_byte_count_next = 2'd0;
        bytes_remaining_next  = '0;
      end
      buffer_position_next = '0;
    end

    pri_res.channel      = marker_held_next[3:0];
    pri_res.block_offset = block_start_next;

    err_res               = '0;
    err_res.result_kind   = tbhp_pkg::KIND_TRUNC;
    err_res.channel       = marker_held_next[3:0];
    err_res.block_offset  = block_start_next;
    err_res.last_of_block = 1'b1;

    push = '0;
    if (accept) begin
      push.cnt    = 2'(pri_valid) + 2'(err_valid);
      push.first  = pri_valid ? pri_res : err_res;
      push.second = err_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= tbhp_pkg::PH_MARKER;
      field_byte_count <= '0;
      marker_held      <= '0;
      time_held        <= '0;
      size_held        <= '0;
      type_held        <= '0;
      param_held       <= '0;
      bytes_remaining  <= '0;
      buffer_position  <= '0;
      block_start      <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      marker_held      <= marker_held_next;
      time_held        <= time_held_next;
      size_held        <= size_held_next;
      type_held        <= type_held_next;
      param_held       <= param_held_next;
      bytes_remaining  <= bytes_remaining_next;
      buffer_position  <= buffer_position_next;
      block_start      <= block_start_next;
    end
  end

  a_content_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == tbhp_pkg::PH_CONTENT) |-> (bytes_remaining != 32'd0))
    else $error("content phase with nothing left");

  a_second_is_trunc: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd2) |-> (push.second.result_kind == tbhp_pkg::KIND_TRUNC &&
                            push.first.result_kind != tbhp_pkg::KIND_TRUNC))
    else $error("double beat without truncation order");

  a_trunc_is_last: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0 && push.first.result_kind == tbhp_pkg::KIND_TRUNC)
      |-> push.first.last_of_block)
    else $error("truncation beat without last");

endmodule

// File: sv/tbhp_out_queue.sv
// small result queue taking up to two results per cycle
module tbhp_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  tbhp_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output tbhp_pkg::result_t   out_res
);

  tbhp_pkg::result_t mem [tbhp_pkg::OQ_DEPTH];

  logic [tbhp_pkg::OQ_AW-1:0] wr_ptr;
  logic [tbhp_pkg::OQ_AW-1:0] rd_ptr;
  logic [tbhp_pkg::OQ_CW-1:0] count;
  logic                       pop;

  assign room      = count <= tbhp_pkg::OQ_CW'(tbhp_pkg::OQ_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + tbhp_pkg::OQ_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tbhp_pkg::OQ_AW'(push.cnt);
      rd_ptr <= rd_ptr + tbhp_pkg::OQ_AW'(pop);
      count  <= count + tbhp_pkg::OQ_CW'(push.cnt) - tbhp_pkg::OQ_CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tbhp_pkg::OQ_CW'(tbhp_pkg::OQ_DEPTH))
    else $error("queue count beyond depth");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> room)
    else $error("push into queue without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd0 && !pop) |=> $stable(count))
    else $error("queue count moved while idle");

endmodule

// File: sv/tagged_block_header_parser.sv
// top level of the tagged block header parser
//
// input: one byte per beat on s_tdata, s_tlast marks the final byte of a
// buffer; the next byte after it starts a new buffer at position zero.
// output: one result per beat; m_tuser gives the kind (header, content
// byte, truncated block), m_tlast marks the final result of a block.
// each input beat is parsed in the cycle it is accepted and its results
// are registered into a four-entry result queue.
// throughput is one byte per cycle while s_tready is high; a byte yields
// at most two results and only a buffer end inside a block yields two,
// so the queue drains the extra beat while further bytes still flow.
// s_tready depends only on queue fill: it drops when fewer than two
// entries are free, so a stalled receiver backs up the input and
// nothing is lost.
// reset (rst, synchronous) empties the queue and returns the parser to
// expecting a marker at buffer position zero.
module tagged_block_header_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // data_byte
  input  logic          s_tlast,   // buffer_end
  output logic          m_tvalid,
  input  logic          m_tready,
  // channel, time_is_absolute, time_value, content_size, has_type,
  // type_value, param_is_wide, param_value, content_byte, block_offset, pad
  output logic [151:0]  m_tdata,
  output logic [1:0]    m_tuser,   // result_kind
  output logic          m_tlast    // last_of_block
);

  tbhp_pkg::push_t   push;
  tbhp_pkg::result_t res;
  logic              room;
  logic              accept;

  assign s_tready = room;
  assign accept   = s_tvalid && room;

  tbhp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .buffer_end (s_tlast),
    .push       (push)
  );

  tbhp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tuser = res.result_kind;
  assign m_tlast = res.last_of_block;
  assign m_tdata = {1'b0, res.block_offset, res.content_byte, res.param_value,
                    res.param_is_wide, res.type_value, res.has_type,
                    res.content_size, res.time_value, res.time_is_absolute,
                    res.channel};

endmodule

// File: bench/tb.sv
// testbench for the tagged block header parser: directed and random byte streams checked against a parse model
module tb;

  localparam int unsigned IDLE_PCT    = 27;
  localparam int unsigned RANDOM_BEATS = 1500;
  localparam int unsigned STALL_AT    = 200;
  localparam int unsigned STALL_LEN   = 300;
  localparam int unsigned WATCHDOG    = 3000;
  localparam int unsigned SHOWN_LIMIT = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  tagged_block_header_parser uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_beat_t          byte_stream [$];
  tbhp_pkg::result_t due_results [$];
  int unsigned total_beats = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned mismatches = 0;
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;
  int unsigned quiet_cycles = 0;
  string       field_names [12] = '{"result_kind", "channel", "time_is_absolute", "time_value",
                                    "content_size", "has_type", "type_value", "param_is_wide",
                                    "param_value", "content_byte", "last_of_block",
                                    "block_offset"};

  wire calm = (beats_in >= 900) && (beats_in < 1150);

  // parser model state
  tbhp_pkg::phase_t ph = tbhp_pkg::PH_MARKER;
  logic [1:0]  fcnt = 2'd0;
  logic [7:0]  mk = 8'd0;
  logic [31:0] t_acc = 32'd0;
  logic [31:0] sz_acc = 32'd0;
  logic [7:0]  ty_acc = 8'd0;
  logic [31:0] p_acc = 32'd0;
  logic [31:0] remaining = 32'd0;
  logic [31:0] pos = 32'd0;
  logic [31:0] blk_pos = 32'd0;

  task automatic gather(inout logic [31:0] acc, input logic [7:0] b, input logic wide,
                        output logic done);
    if (!wide) begin
      acc = {24'd0, b};
      done = 1'b1;
    end else begin
      acc = acc | ({24'd0, b} << (8 * fcnt));
      done = (fcnt == 2'd3);
      fcnt = fcnt + 2'd1;
    end
  endtask

  function automatic tbhp_pkg::result_t blank_result(logic [1:0] kind);
    tbhp_pkg::result_t r;
    r = '0;
    r.result_kind = kind;
    r.channel = mk[3:0];
    r.block_offset = blk_pos;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    logic              done;
    tbhp_pkg::result_t r;
    case (ph)
      tbhp_pkg::PH_TIME: begin
        gather(t_acc, b, !mk[tbhp_pkg::BIT_TIME_ABS], done);
        if (done) ph = tbhp_pkg::PH_SIZE;
      end
      tbhp_pkg::PH_SIZE: begin
        gather(sz_acc, b, !mk[tbhp_pkg::BIT_SIZE_W], done);
        if (done) begin
          if (!mk[tbhp_pkg::BIT_TYPE]) ph = tbhp_pkg::PH_TYPE;
          else ph = tbhp_pkg::PH_PARAM;
        end
      end
      tbhp_pkg::PH_TYPE: begin
        ty_acc = b;
        ph = tbhp_pkg::PH_PARAM;
      end
      tbhp_pkg::PH_PARAM: begin
        gather(p_acc, b, !mk[tbhp_pkg::BIT_PARAM_W], done);
        if (done) begin
          r = blank_result(tbhp_pkg::KIND_HEADER);
          r.time_is_absolute = !mk[tbhp_pkg::BIT_TIME_ABS];
          r.time_value = t_acc;
          r.content_size = sz_acc;
          r.has_type = !mk[tbhp_pkg::BIT_TYPE];
          r.type_value = ty_acc;
          r.param_is_wide = !mk[tbhp_pkg::BIT_PARAM_W];
          r.param_value = p_acc;
          if (sz_acc == 32'd0) begin
            r.last_of_block = 1'b1;
            ph = tbhp_pkg::PH_MARKER;
          end else begin
            remaining = sz_acc;
            ph = tbhp_pkg::PH_CONTENT;
          end
          due_results.push_back(r);
        end
      end
      tbhp_pkg::PH_CONTENT: begin
        r = blank_result(tbhp_pkg::KIND_CONTENT);
        r.content_byte = b;
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) begin
          r.last_of_block = 1'b1;
          ph = tbhp_pkg::PH_MARKER;
        end
        due_results.push_back(r);
      end
      default: begin
        mk = b;
        blk_pos = pos;
        fcnt = 2'd0;
        t_acc = 32'd0;
        sz_acc = 32'd0;
        ty_acc = 8'd0;
        p_acc = 32'd0;
        remaining = 32'd0;
        ph = tbhp_pkg::PH_TIME;
      end
    endcase
    pos = pos + 32'd1;
    if (fin) begin
      if (ph != tbhp_pkg::PH_MARKER) begin
        r = blank_result(tbhp_pkg::KIND_TRUNC);
        r.last_of_block = 1'b1;
        due_results.push_back(r);
        ph = tbhp_pkg::PH_MARKER;
        fcnt = 2'd0;
        remaining = 32'd0;
      end
      pos = 32'd0;
    end
  endtask

  function automatic logic [31:0] field_of(tbhp_pkg::result_t r, int i);
    case (i)
      0:  return {30'd0, r.result_kind};
      1:  return {28'd0, r.channel};
      2:  return {31'd0, r.time_is_absolute};
      3:  return r.time_value;
      4:  return r.content_size;
      5:  return {31'd0, r.has_type};
      6:  return {24'd0, r.type_value};
      7:  return {31'd0, r.param_is_wide};
      8:  return r.param_value;
      9:  return {24'd0, r.content_byte};
      10: return {31'd0, r.last_of_block};
      default: return r.block_offset;
    endcase
  endfunction

  task automatic check_result(input tbhp_pkg::result_t got);
    tbhp_pkg::result_t want;
    bit                bad;
    bad = 1'b0;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_LIMIT)
        $display("unexpected result kind %0d offset %0d", got.result_kind, got.block_offset);
    end else begin
      want = due_results.pop_front();
      for (int i = 0; i < 12; i++) begin
        if (field_of(want, i) !== field_of(got, i)) begin
          if (!bad) mismatches++;
          bad = 1'b1;
          if (mismatches <= SHOWN_LIMIT)
            $display("mismatch on %s: expected %h, got %h", field_names[i],
                     field_of(want, i), field_of(got, i));
        end
      end
    end
  endtask

  task automatic put(input logic [7:0] b, input logic fin);
    in_beat_t x;
    x.data = b;
    x.last = fin;
    byte_stream.push_back(x);
  endtask

  task automatic add_block(input bit cut, input bit big);
    logic [7:0]  bytes [$];
    logic [7:0]  m;
    logic [31:0] sz;
    logic [31:0] w;
    int unsigned n_content;
    int unsigned stop;
    m = 8'($urandom);
    bytes.push_back(m);
    w = $urandom;
    if (!m[tbhp_pkg::BIT_TIME_ABS]) for (int i = 0; i < 4; i++) bytes.push_back(w[8*i +: 8]);
    else bytes.push_back(w[7:0]);
    if (m[tbhp_pkg::BIT_SIZE_W]) begin
      sz = ($urandom_range(99) < 4) ? $urandom_range(255) : $urandom_range(6);
      bytes.push_back(sz[7:0]);
    end else begin
      // huge sizes only on blocks that get cut short
      sz = (big && cut) ? $urandom : $urandom_range(6);
      for (int i = 0; i < 4; i++) bytes.push_back(sz[8*i +: 8]);
    end
    if (!m[tbhp_pkg::BIT_TYPE]) bytes.push_back(8'($urandom));
    w = $urandom;
    if (!m[tbhp_pkg::BIT_PARAM_W]) for (int i = 0; i < 4; i++) bytes.push_back(w[8*i +: 8]);
    else bytes.push_back(w[7:0]);
    n_content = (cut && sz > 10) ? 10 : sz;
    for (int i = 0; i < n_content; i++) bytes.push_back(8'($urandom));
    if (cut) stop = $urandom_range(bytes.size() - 1);
    else stop = bytes.size() - 1;
    for (int i = 0; i <= stop; i++)
      put(bytes[i], (i == stop) && (cut || $urandom_range(3) == 0));
  endtask

  // sender
  always @(posedge clk) begin : drive
    in_beat_t x;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tlast);
        beats_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (byte_stream.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          x = byte_stream.pop_front();
          s_tdata <= x.data;
          s_tlast <= x.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (!stall_done && beats_out == STALL_AT) begin
        stall_left <= STALL_LEN;
        stall_done <= 1'b1;
      end
    end
  end

  // receiver
  always @(posedge clk) begin : monitor
    tbhp_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.result_kind = m_tuser;
      got.channel = m_tdata[3:0];
      got.time_is_absolute = m_tdata[4];
      got.time_value = m_tdata[36:5];
      got.content_size = m_tdata[68:37];
      got.has_type = m_tdata[69];
      got.type_value = m_tdata[77:70];
      got.param_is_wide = m_tdata[78];
      got.param_value = m_tdata[110:79];
      got.content_byte = m_tdata[118:111];
      got.block_offset = m_tdata[150:119];
      got.last_of_block = m_tlast;
      check_result(got);
      beats_out++;
    end
    m_tready <= !rst && (stall_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    // all flags active, extreme values, empty content
    put(8'h00, 1'b0); put(8'hff, 1'b0); put(8'hff, 1'b0); put(8'hff, 1'b0);
    put(8'hff, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
    put(8'h00, 1'b0); put(8'hff, 1'b0); put(8'hff, 1'b0); put(8'hff, 1'b0);
    put(8'hff, 1'b0); put(8'hff, 1'b0);
    // all flags inactive, two content bytes, buffer ends on the last one
    put(8'hff, 1'b0); put(8'hff, 1'b0); put(8'h02, 1'b0); put(8'h00, 1'b0);
    put(8'haa, 1'b0); put(8'h55, 1'b1);
    // buffer ends right after a marker
    put(8'h3c, 1'b1);
    // buffer ends on the last header byte of a block with content
    put(8'hf5, 1'b0); put(8'h01, 1'b0); put(8'h03, 1'b0); put(8'h07, 1'b1);
    while (byte_stream.size() < RANDOM_BEATS) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(5)) put(8'($urandom), $urandom_range(4) == 0);
        put(8'($urandom), 1'b1);
      end else begin
        add_block($urandom_range(99) < 20, $urandom_range(1) == 1);
      end
    end
    total_beats = byte_stream.size();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (beats_in < total_beats) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
